// ===== sv/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hash engine.
package sha_pkg;

  localparam int BLK_WORDS = 16;
  localparam int H_WORDS   = 8;
  localparam int BLK_AW    = $clog2(BLK_WORDS);
  localparam int H_AW      = $clog2(H_WORDS);

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [H_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT_RD,
    ST_OUT_HI,
    ST_OUT_LO
  } state_t;

  typedef struct packed {
    logic            w_shift;
    logic            s_load;
    logic            round_en;
    logic [H_AW-1:0] s_sel;
    logic [5:0]      round_idx;
  } rnd_ctrl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== sv/sha_if.sv =====
// Valid/ready channel interfaces for the input and digest sides.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

// ===== sv/sha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sha_round.sv =====
// Working variables, message schedule window and the one-round-per-cycle datapath.
module sha_round (
  input  logic                     clk,
  input  sha_pkg::rnd_ctrl_t       ctrl,
  input  logic [31:0]              w_in,
  input  logic [31:0]              h_in,
  output logic [31:0]              s_word
);

  logic [31:0] w_r [sha_pkg::BLK_WORDS];
  logic [31:0] s_r [sha_pkg::H_WORDS];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign w_new = sha_pkg::small_sigma1(w_r[14]) + w_r[9] +
                 sha_pkg::small_sigma0(w_r[1]) + w_r[0];

  assign t1 = s_r[7] + sha_pkg::big_sigma1(s_r[4]) +
              sha_pkg::choose(s_r[4], s_r[5], s_r[6]) +
              sha_pkg::ROUND_K[ctrl.round_idx] + w_r[0];
  assign t2 = sha_pkg::big_sigma0(s_r[0]) + sha_pkg::majority(s_r[0], s_r[1], s_r[2]);

  assign s_word = s_r[ctrl.s_sel];

  always_ff @(posedge clk) begin
    if (ctrl.w_shift || ctrl.round_en) begin
      for (int j = 0; j < sha_pkg::BLK_WORDS - 1; j++) begin
        w_r[j] <= w_r[j+1];
      end
      w_r[sha_pkg::BLK_WORDS-1] <= ctrl.round_en ? w_new : w_in;
    end
    if (ctrl.round_en) begin
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end else if (ctrl.s_load) begin
      s_r[ctrl.s_sel] <= h_in;
    end
  end

endmodule

// ===== sv/sha256_hash_engine.sv =====
// SHA-256 hash engine top level: sequencer, block memory and hash memory.
// Message bytes are taken one per cycle while the engine is idle and packed
// into 32-bit words of a 16-word block memory; the eight hash words live in a
// second memory. While a full block is processed no word is taken: the
// schedule window and working variables are loaded from the two memories, the
// rounds run (one round per cycle in the round unit), and the hash words are
// read, added and written back. An end marker causes padding writes up to the
// end of the block plus one block when fewer than 56 bytes are held; otherwise
// it costs at most one padding write, a block, a padding write to every word
// of the block and a second block. Then each digest word is read from the
// hash memory in ST_OUT_RD, ST_OUT_HI and ST_OUT_LO; ST_OUT_RD waits while
// the output register is still full. After reset the hash memory is loaded
// with the initial values before the first word is taken. The last digest
// word may wait in the output register while the next message starts.
module sha256_hash_engine (
  input  logic             clk,
  input  logic             rst_n,
  sha_in_if.sink           in_chan,
  sha_out_if.source        out_chan
);

  sha_pkg::state_t state_r;
  sha_pkg::state_t state_nxt;

  logic [5:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [60:0] bytecnt_r;
  logic [23:0] acc_r;
  logic [3:0]  wp_r;
  logic        fin_r;
  logic        len_r;
  logic [1:0]  k_r;
  logic [31:0] hi_r;
  logic        out_valid_r;
  logic [63:0] out_word_r;
  logic [1:0]  out_idx_r;
  logic        out_last_r;

  logic                     bm_we;
  logic [sha_pkg::BLK_AW-1:0] bm_waddr;
  logic [31:0]              bm_wdata;
  logic [sha_pkg::BLK_AW-1:0] bm_raddr;
  logic [31:0]              bm_rdata;
  logic                     hm_we;
  logic [sha_pkg::H_AW-1:0] hm_waddr;
  logic [31:0]              hm_wdata;
  logic [sha_pkg::H_AW-1:0] hm_raddr;
  logic [31:0]              hm_rdata;

  sha_pkg::rnd_ctrl_t rc;
  logic [31:0] s_word;
  logic        in_fire;
  logic        out_fire;
  logic [63:0] bit_len;
  logic [31:0] pad_word;
  logic [31:0] byte_word;
  logic [2:0]  cnt_m1;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign bit_len  = {bytecnt_r, 3'b000};
  assign cnt_m1   = cnt_r[2:0] - 3'd1;
  assign byte_word = {acc_r, in_chan.data_byte};

  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_word = {sha_pkg::PAD_BYTE, 24'd0};
      2'd1:    pad_word = {acc_r[7:0], sha_pkg::PAD_BYTE, 16'd0};
      2'd2:    pad_word = {acc_r[15:0], sha_pkg::PAD_BYTE, 8'd0};
      default: pad_word = {acc_r[23:0], sha_pkg::PAD_BYTE};
    endcase
  end

  assign in_chan.ready        = (state_r == sha_pkg::ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.last        = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_INIT: begin
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.kind == sha_pkg::KIND_END) begin
            state_nxt = (fill_r[5:2] == 4'd15) ? sha_pkg::ST_LOAD : sha_pkg::ST_PAD;
          end else if (fill_r == 6'd63) begin
            state_nxt = sha_pkg::ST_LOAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (wp_r == 4'd15) begin
          state_nxt = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_LOAD: begin
        if (cnt_r == 6'd16) begin
          state_nxt = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        if (cnt_r == 6'd63) begin
          state_nxt = sha_pkg::ST_UPDATE;
        end
      end
      sha_pkg::ST_UPDATE: begin
        if (cnt_r == 6'd8) begin
          if (fin_r && !len_r) begin
            state_nxt = sha_pkg::ST_PAD;
          end else if (fin_r) begin
            state_nxt = sha_pkg::ST_OUT_RD;
          end else begin
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      sha_pkg::ST_OUT_RD: begin
        if (!out_valid_r) begin
          state_nxt = sha_pkg::ST_OUT_HI;
        end
      end
      sha_pkg::ST_OUT_HI: begin
        state_nxt = sha_pkg::ST_OUT_LO;
      end
      sha_pkg::ST_OUT_LO: begin
        state_nxt = (k_r == 2'd3) ? sha_pkg::ST_IDLE : sha_pkg::ST_OUT_RD;
      end
      default: begin
        state_nxt = sha_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    bm_we        = 1'b0;
    bm_waddr     = fill_r[5:2];
    bm_wdata     = byte_word;
    bm_raddr     = cnt_r[3:0];
    hm_we        = 1'b0;
    hm_waddr     = cnt_m1;
    hm_wdata     = hm_rdata + s_word;
    hm_raddr     = cnt_r[2:0];
    rc.w_shift   = 1'b0;
    rc.s_load    = 1'b0;
    rc.round_en  = 1'b0;
    rc.s_sel     = cnt_m1;
    rc.round_idx = cnt_r;
    unique case (state_r)
      sha_pkg::ST_INIT: begin
        hm_we    = 1'b1;
        hm_waddr = cnt_r[2:0];
        hm_wdata = sha_pkg::INIT_H[cnt_r[2:0]];
      end
      sha_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.kind == sha_pkg::KIND_END) begin
            bm_we    = 1'b1;
            bm_wdata = pad_word;
          end else begin
            bm_we = (fill_r[1:0] == 2'd3);
          end
        end
      end
      sha_pkg::ST_PAD: begin
        bm_we    = 1'b1;
        bm_waddr = wp_r;
        if (len_r && wp_r == 4'd14) begin
          bm_wdata = bit_len[63:32];
        end else if (len_r && wp_r == 4'd15) begin
          bm_wdata = bit_len[31:0];
        end else begin
          bm_wdata = 32'd0;
        end
      end
      sha_pkg::ST_LOAD: begin
        rc.w_shift = (cnt_r != 6'd0);
        rc.s_load  = (cnt_r != 6'd0) && (cnt_r <= 6'd8);
      end
      sha_pkg::ST_ROUND: begin
        rc.round_en = 1'b1;
      end
      sha_pkg::ST_UPDATE: begin
        hm_we = (cnt_r != 6'd0);
      end
      sha_pkg::ST_OUT_RD: begin
        hm_raddr = {k_r, 1'b0};
      end
      sha_pkg::ST_OUT_HI: begin
        hm_raddr = {k_r, 1'b1};
        hm_we    = 1'b1;
        hm_waddr = {k_r, 1'b0};
        hm_wdata = sha_pkg::INIT_H[{k_r, 1'b0}];
      end
      sha_pkg::ST_OUT_LO: begin
        hm_we    = 1'b1;
        hm_waddr = {k_r, 1'b1};
        hm_wdata = sha_pkg::INIT_H[{k_r, 1'b1}];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_INIT;
      cnt_r       <= 6'd0;
      fill_r      <= 6'd0;
      bytecnt_r   <= 61'd0;
      wp_r        <= 4'd0;
      fin_r       <= 1'b0;
      len_r       <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= 6'd0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        sha_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_chan.kind == sha_pkg::KIND_END) begin
              fin_r <= 1'b1;
              len_r <= (fill_r[5:3] != 3'd7);
              wp_r  <= fill_r[5:2] + 4'd1;
            end else begin
              fill_r    <= fill_r + 6'd1;
              bytecnt_r <= bytecnt_r + 61'd1;
            end
          end
        end
        sha_pkg::ST_PAD: begin
          wp_r <= wp_r + 4'd1;
        end
        sha_pkg::ST_UPDATE: begin
          if (cnt_r == 6'd8) begin
            if (fin_r && !len_r) begin
              len_r <= 1'b1;
              wp_r  <= 4'd0;
            end
            k_r <= 2'd0;
          end
        end
        sha_pkg::ST_OUT_LO: begin
          out_valid_r <= 1'b1;
          if (k_r == 2'd3) begin
            fill_r    <= 6'd0;
            bytecnt_r <= 61'd0;
            fin_r     <= 1'b0;
            len_r     <= 1'b0;
          end
          k_r <= k_r + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.kind == sha_pkg::KIND_BYTE) begin
      acc_r <= byte_word[23:0];
    end
    if (state_r == sha_pkg::ST_OUT_HI) begin
      hi_r <= hm_rdata;
    end
    if (state_r == sha_pkg::ST_OUT_LO) begin
      out_word_r <= {hi_r, hm_rdata};
      out_idx_r  <= k_r;
      out_last_r <= (k_r == 2'd3);
    end
  end

  sha_ram #(
    .WIDTH (32),
    .DEPTH (sha_pkg::BLK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  sha_ram #(
    .WIDTH (32),
    .DEPTH (sha_pkg::H_WORDS)
  ) u_hash_ram (
    .clk   (clk),
    .we    (hm_we),
    .waddr (hm_waddr),
    .wdata (hm_wdata),
    .raddr (hm_raddr),
    .rdata (hm_rdata)
  );

  sha_round u_round (
    .clk    (clk),
    .ctrl   (rc),
    .w_in   (bm_rdata),
    .h_in   (hm_rdata),
    .s_word (s_word)
  );

endmodule

// ===== dv/tb_sha256_hash_engine.sv =====
// Self-checking testbench for the SHA-256 hash engine with a digest scoreboard.
module tb_sha256_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WORDS = 170;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } digest_part_t;

  class sha256_digest_scoreboard;
    logic [31:0]  hash_state [8];
    logic [7:0]   block_buf [64];
    int unsigned  fill;
    logic [60:0]  msg_bytes;
    digest_part_t expected_digests [$];
    int unsigned  errors;

    function new();
      hash_state = HASH_START;
      fill = 0;
      msg_bytes = '0;
      errors = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
             ROUND_CONST[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function void note_word(logic kind, logic [7:0] data_byte);
      logic [63:0]  bit_len;
      digest_part_t part;
      if (kind == sha_pkg::KIND_BYTE) begin
        block_buf[fill] = data_byte;
        fill = (fill + 1) % 64;
        msg_bytes = msg_bytes + 61'd1;
        if (fill == 0) begin
          compress_block();
        end
        return;
      end
      block_buf[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) begin
        block_buf[i] = 8'h00;
      end
      if (fill > 55) begin
        compress_block();
        for (int i = 0; i < 64; i++) begin
          block_buf[i] = 8'h00;
        end
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) begin
        block_buf[56 + i] = bit_len[63 - 8*i -: 8];
      end
      compress_block();
      for (int k = 0; k < 4; k++) begin
        part.digest_word = {hash_state[2*k], hash_state[2*k+1]};
        part.word_index  = k[1:0];
        part.last        = (k == 3);
        expected_digests.push_back(part);
      end
      hash_state = HASH_START;
      fill = 0;
      msg_bytes = '0;
    endfunction

    function void check_digest(logic [63:0] digest_word, logic [1:0] word_index,
                               logic last);
      digest_part_t exp_part;
      if (expected_digests.size() == 0) begin
        $error("Unexpected digest word %h (index %0d)", digest_word, word_index);
        errors++;
        return;
      end
      exp_part = expected_digests.pop_front();
      if (digest_word !== exp_part.digest_word) begin
        $error("digest_word: expected %h, got %h", exp_part.digest_word, digest_word);
        errors++;
      end
      if (word_index !== exp_part.word_index) begin
        $error("word_index: expected %0d, got %0d", exp_part.word_index, word_index);
        errors++;
      end
      if (last !== exp_part.last) begin
        $error("last: expected %0b, got %0b", exp_part.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sha_in_if  in_chan ();
  sha_out_if out_chan ();

  sha256_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha256_digest_scoreboard digest_sb = new();
  int unsigned idle_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      digest_sb.note_word(in_chan.kind, in_chan.data_byte);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      digest_sb.check_digest(out_chan.digest_word, out_chan.word_index, out_chan.last);
    end
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int mode;
    int unsigned cnt;
    out_chan.ready = 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (cnt % 50 == 0) begin
        mode = $urandom_range(0, 3);
      end
      cnt++;
      case (mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom_range(0, 1));
        2: out_chan.ready <= (cnt % 4 == 0);
        default: out_chan.ready <= (cnt % 16 >= 10);
      endcase
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] data_byte);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= kind;
    in_chan.data_byte <= data_byte;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_word(sha_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
    end
    send_word(sha_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = sha_pkg::KIND_BYTE;
    in_chan.data_byte = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty message whose end marker carries a nonzero byte that must be ignored.
    send_word(sha_pkg::KIND_END, 8'hff);
    send_word(sha_pkg::KIND_BYTE, 8'h61);
    send_word(sha_pkg::KIND_BYTE, 8'h62);
    send_word(sha_pkg::KIND_BYTE, 8'h63);
    send_word(sha_pkg::KIND_END, 8'h00);
    send_word(sha_pkg::KIND_BYTE, 8'h00);
    send_word(sha_pkg::KIND_BYTE, 8'hff);
    send_word(sha_pkg::KIND_END, 8'h5a);
    send_word(sha_pkg::KIND_BYTE, 8'h80);
    send_word(sha_pkg::KIND_END, 8'h00);
    send_word(sha_pkg::KIND_END, 8'h00);
    send_word(sha_pkg::KIND_END, 8'h01);

    // Padding that needs a second block, then a message that fills a whole block.
    send_message($urandom_range(56, 63));
    send_message($urandom_range(64, 70));
    while (words_sent < RANDOM_WORDS) begin
      send_message(($urandom_range(0, 7) == 0) ? $urandom_range(48, 63)
                                               : $urandom_range(0, 10));
    end
    in_chan.valid <= 1'b0;

    while (digest_sb.expected_digests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (digest_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
